FILE: src/fppd_pkg.sv
`default_nettype none

package fppd_pkg;

  // Sequencer states of the shared multiplier datapath.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ERRDT,
    S_PE,
    S_K,
    S_IC,
    S_SUM,
    S_DIV,
    S_QUO,
    S_FIN
  } state_t;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_UPDATE  = 2'd0,
    CMD_PRIME   = 2'd1,
    CMD_DISABLE = 2'd2,
    CMD_POLL    = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_THRESHOLD_SPEED = 3'd0;
  localparam logic [2:0] REG_TARGET_HIGH     = 3'd1;
  localparam logic [2:0] REG_TARGET_LOW      = 3'd2;
  localparam logic [2:0] REG_GAIN_PROP       = 3'd3;
  localparam logic [2:0] REG_GAIN_INTEG      = 3'd4;
  localparam logic [2:0] REG_PRIME_LENGTH    = 3'd5;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Controller output accumulator width (covers both gain terms).
  localparam int OUT_W = 38;

  // Integrator clamp, at the width of the pre-clamp sum and of the store.
  localparam logic signed [28:0] INTEG_HI_SUM = 29'sd320000;
  localparam logic signed [28:0] INTEG_LO_SUM = -29'sd320000;
  localparam logic signed [19:0] INTEG_HI     = 20'sd320000;
  localparam logic signed [19:0] INTEG_LO     = -20'sd320000;

  // Output level at which the duty saturates (255 * 16000).
  localparam logic signed [OUT_W-1:0] OUT_FULL = 38'sd4080000;

  // Error scale on the proportional term.
  localparam logic signed [MUL_B_W-1:0] ERR_SCALE = 24'sd1000;

  // Divide by 16000 as a multiply by ceil(2^36 / 16000) and a shift by 36.
  // Exact for every dividend below 2^22.
  localparam logic signed [MUL_B_W-1:0] DIV_RECIP = 24'sd4294968;
  localparam int DIV_SHIFT = 36;

  localparam logic [7:0] DUTY_MAX = 8'd255;

endpackage

`default_nettype wire

FILE: src/fuel_pressure_pi_pump_drive_unit.sv
// Fuel pump pressure PI regulator with conditional integration and 8-bit PWM duty.
// An update item steps through the states ERRDT, PE, K, IC, SUM, DIV and QUO to FIN;
// prime, disable and poll act at accept and go straight to FIN. In FIN the result is
// loaded once the output register is free, and only then does the block return to IDLE
// and take the next item. The update sequence uses the single shared 28x24 multiplier
// five times, in ERRDT, PE, K, IC and DIV. Reset (rst_n, synchronous, active low)
// clears the configuration registers, the sequencer and controller state and the output.
`default_nettype none

module fuel_pressure_pi_pump_drive_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_pressure,
  input  wire logic [15:0] in_engine_speed,
  input  wire logic [31:0] in_now_ms,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_pwm_duty,
  output logic             out_prime_active
);

  // Configuration registers.
  logic [15:0] threshold_speed_r;
  logic [9:0]  target_high_r;
  logic [9:0]  target_low_r;
  logic [14:0] gain_prop_r;
  logic [14:0] gain_integ_r;
  logic [15:0] prime_length_r;

  // Controller state.
  logic signed [19:0] integ_r;
  logic [31:0]        last_time_r;
  logic               prime_r;
  logic [31:0]        deadline_r;
  logic [7:0]         duty_r;

  // Sequencer and working registers.
  fppd_pkg::state_t state_r, state_nxt;
  logic signed [10:0]                  err_r;
  logic [15:0]                         dt_r;
  logic signed [19:0]                  cand_r;
  logic signed [fppd_pkg::OUT_W-1:0]   acc_r;
  logic signed [fppd_pkg::OUT_W-1:0]   out_r;
  logic signed [fppd_pkg::MUL_P_W-1:0] prod_r;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_duty_r;
  logic       out_prime_r;

  // Combinational signals.
  logic                                in_fire;
  logic                                out_free;
  logic [9:0]                          target;
  logic [15:0]                         dt_raw;
  logic signed [fppd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [fppd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [fppd_pkg::MUL_P_W-1:0] mul_p;
  logic signed [28:0]                  integ_sum;
  logic signed [19:0]                  cand_clamped;
  logic signed [fppd_pkg::OUT_W-1:0]   out_sum;
  logic                                err_neg;
  logic                                err_pos;
  logic                                sat_low;
  logic                                sat_high;
  logic                                out_le_zero;
  logic                                out_ge_full;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_pwm_duty     = out_duty_r;
  assign out_prime_active = out_prime_r;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_speed_r <= '0;
      target_high_r     <= '0;
      target_low_r      <= '0;
      gain_prop_r       <= '0;
      gain_integ_r      <= '0;
      prime_length_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fppd_pkg::REG_THRESHOLD_SPEED: threshold_speed_r <= cfg_wdata;
        fppd_pkg::REG_TARGET_HIGH:     target_high_r     <= cfg_wdata[9:0];
        fppd_pkg::REG_TARGET_LOW:      target_low_r      <= cfg_wdata[9:0];
        fppd_pkg::REG_GAIN_PROP:       gain_prop_r       <= cfg_wdata[14:0];
        fppd_pkg::REG_GAIN_INTEG:      gain_integ_r      <= cfg_wdata[14:0];
        fppd_pkg::REG_PRIME_LENGTH:    prime_length_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Target selection and elapsed time at accept.
  assign target = (in_engine_speed >= threshold_speed_r) ? target_high_r : target_low_r;
  assign dt_raw = 16'(in_now_ms - last_time_r);

  // Integrator candidate: add the error-time product and clamp.
  assign integ_sum = {{9{integ_r[19]}}, integ_r} + prod_r[28:0];
  always_comb begin
    if (integ_sum > fppd_pkg::INTEG_HI_SUM) begin
      cand_clamped = fppd_pkg::INTEG_HI;
    end else if (integ_sum < fppd_pkg::INTEG_LO_SUM) begin
      cand_clamped = fppd_pkg::INTEG_LO;
    end else begin
      cand_clamped = integ_sum[19:0];
    end
  end

  // Controller output and the anti-windup decision.
  assign out_sum  = acc_r + prod_r[fppd_pkg::OUT_W-1:0];
  assign err_neg  = err_r[10];
  assign err_pos  = !err_r[10] && (err_r != 11'sd0);
  assign sat_low  = (out_sum[fppd_pkg::OUT_W-1] || (out_sum == '0)) && err_neg;
  assign sat_high = (out_sum >= fppd_pkg::OUT_FULL) && err_pos;

  // Duty range checks on the registered output.
  assign out_le_zero = out_r[fppd_pkg::OUT_W-1] || (out_r == '0);
  assign out_ge_full = out_r >= fppd_pkg::OUT_FULL;

  // Shared multiplier.
  assign mul_p = mul_a * mul_b;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fppd_pkg::S_IDLE: begin
        if (in_valid) begin
          if (fppd_pkg::cmd_t'(in_command) == fppd_pkg::CMD_UPDATE) begin
            state_nxt = fppd_pkg::S_ERRDT;
          end else begin
            state_nxt = fppd_pkg::S_FIN;
          end
        end
      end
      fppd_pkg::S_ERRDT: state_nxt = fppd_pkg::S_PE;
      fppd_pkg::S_PE:    state_nxt = fppd_pkg::S_K;
      fppd_pkg::S_K:     state_nxt = fppd_pkg::S_IC;
      fppd_pkg::S_IC:    state_nxt = fppd_pkg::S_SUM;
      fppd_pkg::S_SUM:   state_nxt = fppd_pkg::S_DIV;
      fppd_pkg::S_DIV:   state_nxt = fppd_pkg::S_QUO;
      fppd_pkg::S_QUO:   state_nxt = fppd_pkg::S_FIN;
      fppd_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = fppd_pkg::S_IDLE;
        end
      end
      default: state_nxt = fppd_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and multiplier operand selection.
  always_comb begin
    in_stall = (state_r != fppd_pkg::S_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      fppd_pkg::S_ERRDT: begin
        mul_a = {{17{err_r[10]}}, err_r};
        mul_b = {8'd0, dt_r};
      end
      fppd_pkg::S_PE: begin
        mul_a = {{17{err_r[10]}}, err_r};
        mul_b = {9'd0, gain_prop_r};
      end
      fppd_pkg::S_K: begin
        mul_a = prod_r[fppd_pkg::MUL_A_W-1:0];
        mul_b = fppd_pkg::ERR_SCALE;
      end
      fppd_pkg::S_IC: begin
        mul_a = {{8{cand_r[19]}}, cand_r};
        mul_b = {9'd0, gain_integ_r};
      end
      fppd_pkg::S_DIV: begin
        mul_a = {6'd0, out_r[21:0]};
        mul_b = fppd_pkg::DIV_RECIP;
      end
      default: ;
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fppd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Controller state: immediate commands act at accept, updates at their steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      last_time_r <= '0;
      prime_r     <= 1'b0;
      deadline_r  <= '0;
      duty_r      <= '0;
    end else if (in_fire) begin
      case (fppd_pkg::cmd_t'(in_command))
        fppd_pkg::CMD_UPDATE: begin
          last_time_r <= in_now_ms;
        end
        fppd_pkg::CMD_PRIME: begin
          prime_r    <= 1'b1;
          deadline_r <= in_now_ms + {16'd0, prime_length_r};
          duty_r     <= fppd_pkg::DUTY_MAX;
        end
        fppd_pkg::CMD_DISABLE: begin
          prime_r <= 1'b0;
          integ_r <= '0;
          duty_r  <= '0;
        end
        fppd_pkg::CMD_POLL: begin
          if (prime_r && (in_now_ms >= deadline_r)) begin
            prime_r <= 1'b0;
            duty_r  <= '0;
          end
        end
        default: ;
      endcase
    end else if (state_r == fppd_pkg::S_SUM) begin
      if (!sat_low && !sat_high) begin
        integ_r <= cand_r;
      end
    end else if (state_r == fppd_pkg::S_QUO) begin
      if (out_le_zero) begin
        duty_r <= '0;
      end else if (out_ge_full) begin
        duty_r <= fppd_pkg::DUTY_MAX;
      end else begin
        duty_r <= prod_r[fppd_pkg::DIV_SHIFT+7:fppd_pkg::DIV_SHIFT];
      end
    end
  end

  // Working registers of the update sequence.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r <= $signed({1'b0, target}) - $signed({3'd0, in_pressure});
      dt_r  <= (dt_raw == 16'd0) ? 16'd1 : dt_raw;
    end
    case (state_r)
      fppd_pkg::S_PE:  cand_r <= cand_clamped;
      fppd_pkg::S_IC:  acc_r  <= prod_r[fppd_pkg::OUT_W-1:0];
      fppd_pkg::S_SUM: out_r  <= out_sum;
      default: ;
    endcase
    prod_r <= mul_p;
  end

  // Output register: loads when the previous result has been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_duty_r  <= '0;
      out_prime_r <= 1'b0;
    end else begin
      if ((state_r == fppd_pkg::S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
        out_duty_r  <= duty_r;
        out_prime_r <= prime_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The integrator never leaves its clamp range.
  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= fppd_pkg::INTEG_HI) && (integ_r >= fppd_pkg::INTEG_LO))
    else $error("integrator outside clamp range");

  // Start priming forces full duty and sets the flag.
  a_prime_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_command == fppd_pkg::CMD_PRIME) |=> prime_r && (duty_r == fppd_pkg::DUTY_MAX))
    else $error("priming start not applied");

  // Disable clears the controller.
  a_disable: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_command == fppd_pkg::CMD_DISABLE)
    |=> !prime_r && (integ_r == 20'sd0) && (duty_r == 8'd0))
    else $error("disable did not clear state");

  // An accepted item always leaves the idle state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != fppd_pkg::S_IDLE))
    else $error("accepted item not processed");

  // A result is only loaded from the final state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == fppd_pkg::S_FIN))
    else $error("result loaded outside the final state");

endmodule

`default_nettype wire

FILE: tb/fuel_pressure_pi_pump_drive_unit_tb.sv
`timescale 1ns / 100ps

module fuel_pressure_pi_pump_drive_unit_tb;

  // Controller constants, kept at 64 bits so no product can wrap.
  localparam longint INTEG_CLAMP    = 320000;
  localparam longint FULL_SCALE_OUT = 4080000;
  localparam longint DUTY_DIVISOR   = 16000;
  localparam longint ERR_MULT       = 1000;
  localparam longint DUTY_TOP       = 255;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AT_A     = 100;
  localparam int HOLD_AT_B     = 330;
  localparam int PHASE_ITEMS   = 125;
  localparam int NUM_PHASES    = 7;
  localparam int MAX_REPORTS   = 10;
  localparam int MAX_WAIT      = 11;

  // Highest index on the register port; those past the last register do nothing.
  localparam logic [2:0] REG_SPARE_TOP = 3'd7;

  typedef struct packed {
    fppd_pkg::cmd_t cmd;
    logic [7:0]     pressure;
    logic [15:0]    speed;
    logic [31:0]    now_ms;
  } pump_item_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       prime;
  } pump_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [7:0]  in_pressure = '0;
  logic [15:0] in_engine_speed = '0;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_pwm_duty;
  logic        out_prime_active;

  fuel_pressure_pi_pump_drive_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_pressure      (in_pressure),
    .in_engine_speed  (in_engine_speed),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pwm_duty     (out_pwm_duty),
    .out_prime_active (out_prime_active)
  );

  // Mirror of the register file.
  logic [15:0] speed_knee = '0;
  logic [9:0]  tgt_hi = '0;
  logic [9:0]  tgt_lo = '0;
  logic [14:0] kp = '0;
  logic [14:0] ki = '0;
  logic [15:0] prime_ms = '0;

  // Mirror of the controller state.
  logic signed [19:0] integ_sum = '0;
  logic [31:0]        prev_ms = '0;
  logic               priming = 1'b0;
  logic [31:0]        prime_due_ms = '0;
  logic [7:0]         duty_now = '0;

  pump_item_t   pending_q[$];
  pump_result_t duty_expect_q[$];
  pump_item_t   cur_item;
  pump_result_t want;

  int cycle_count = 0;
  int stim_total = 0;
  int results_seen = 0;
  int mismatches = 0;
  int holds_done = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int cmd_seen [4];
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;
  logic [31:0] ms_clock = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Advance the controller mirror by one accepted item and queue what it should report.
  task automatic apply_item(input pump_item_t it);
    logic [9:0]   tgt;
    logic [31:0]  elapsed;
    longint       err;
    longint       dt;
    longint       cand;
    longint       ctrl;
    longint       q;
    logic         hold_low;
    logic         hold_high;
    pump_result_t res;
    case (it.cmd)
      fppd_pkg::CMD_UPDATE: begin
        tgt = (it.speed >= speed_knee) ? tgt_hi : tgt_lo;
        err = longint'(tgt) - longint'(it.pressure);
        elapsed = it.now_ms - prev_ms;
        dt = longint'(elapsed[15:0]);
        if (dt == 0) dt = 1;
        prev_ms = it.now_ms;
        cand = longint'(integ_sum) + err * dt;
        if (cand > INTEG_CLAMP) cand = INTEG_CLAMP;
        if (cand < -INTEG_CLAMP) cand = -INTEG_CLAMP;
        ctrl = longint'(kp) * err * ERR_MULT + longint'(ki) * cand;
        // The integrator only moves when the output is not pinned in the error's direction.
        hold_low = (ctrl <= 0) && (err < 0);
        hold_high = (ctrl >= FULL_SCALE_OUT) && (err > 0);
        if (!hold_low && !hold_high) integ_sum = 20'(cand);
        q = ctrl / DUTY_DIVISOR;
        if (q < 0) q = 0;
        if (q > DUTY_TOP) q = DUTY_TOP;
        duty_now = 8'(q);
      end
      fppd_pkg::CMD_PRIME: begin
        priming = 1'b1;
        prime_due_ms = it.now_ms + {16'd0, prime_ms};
        duty_now = fppd_pkg::DUTY_MAX;
      end
      fppd_pkg::CMD_DISABLE: begin
        priming = 1'b0;
        integ_sum = '0;
        duty_now = '0;
      end
      fppd_pkg::CMD_POLL: begin
        if (priming && it.now_ms >= prime_due_ms) begin
          duty_now = '0;
          priming = 1'b0;
        end
      end
      default: ;
    endcase
    res.duty = duty_now;
    res.prime = priming;
    duty_expect_q.push_back(res);
  endtask

  // Sender: presents queued items, with a random pause after each one unless the source is steady.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_item(cur_item);
        cmd_seen[cur_item.cmd]++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur_item = pending_q.pop_front();
          in_command <= cur_item.cmd;
          in_pressure <= cur_item.pressure;
          in_engine_speed <= cur_item.speed;
          in_now_ms <= cur_item.now_ms;
          in_valid <= 1'b1;
          send_gap = src_steady ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest prediction and stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (duty_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d arrived with nothing expected: duty %0d prime %0b",
                     results_seen, out_pwm_duty, out_prime_active);
        end else begin
          want = duty_expect_q.pop_front();
          if (out_pwm_duty !== want.duty || out_prime_active !== want.prime) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d: expected duty %0d prime %0b, got duty %0d prime %0b",
                       results_seen, want.duty, want.prime, out_pwm_duty, out_prime_active);
          end
        end
        recv_gap = sink_steady ? 0 : $urandom_range(0, MAX_WAIT);
        // Long back-pressure so the block fills and holds off the sender.
        if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) begin
          hold_left = HOLD_CYCLES;
          holds_done++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_item(input fppd_pkg::cmd_t c, input logic [7:0] p,
                            input logic [15:0] s, input logic [31:0] now);
    pump_item_t it;
    it.cmd = c;
    it.pressure = p;
    it.speed = s;
    it.now_ms = now;
    pending_q.push_back(it);
    stim_total++;
  endtask

  // Mostly plausible control traffic: time mostly moves forward, pressure hovers near the target.
  task automatic queue_random_item();
    int             pick;
    int             p;
    logic [15:0]    spd;
    logic [9:0]     tgt;
    fppd_pkg::cmd_t c;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // Same millisecond as before.
    end else if (pick < 11) begin
      ms_clock += $urandom_range(60000, 140000);
    end else if (pick < 14) begin
      ms_clock = $urandom;
    end else begin
      ms_clock += $urandom_range(1, 40);
    end
    pick = $urandom_range(0, 99);
    if (pick < 62) c = fppd_pkg::CMD_UPDATE;
    else if (pick < 74) c = fppd_pkg::CMD_PRIME;
    else if (pick < 92) c = fppd_pkg::CMD_POLL;
    else c = fppd_pkg::CMD_DISABLE;
    if ($urandom_range(0, 1) == 0) spd = speed_knee + 16'($urandom_range(0, 6)) - 16'd3;
    else spd = 16'($urandom);
    tgt = (spd >= speed_knee) ? tgt_hi : tgt_lo;
    if ($urandom_range(0, 99) < 70) begin
      p = int'(tgt) + $urandom_range(0, 80) - 40;
      if (p < 0) p = 0;
      if (p > 255) p = 255;
    end else begin
      p = $urandom_range(0, 255);
    end
    queue_item(c, 8'(p), spd, ms_clock);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      fppd_pkg::REG_THRESHOLD_SPEED: speed_knee = val;
      fppd_pkg::REG_TARGET_HIGH:     tgt_hi = val[9:0];
      fppd_pkg::REG_TARGET_LOW:      tgt_lo = val[9:0];
      fppd_pkg::REG_GAIN_PROP:       kp = val[14:0];
      fppd_pkg::REG_GAIN_INTEG:      ki = val[14:0];
      fppd_pkg::REG_PRIME_LENGTH:    prime_ms = val;
      default: ;
    endcase
  endtask

  // Fixed register settings: speed knee, high target, low target, Kp, Ki, prime time.
  function automatic logic [95:0] preset_row(input int row);
    case (row)
      0: return {16'd2000, 16'd800, 16'd160, 16'd5, 16'd1, 16'd1000};
      1: return {16'd2500, 16'd640, 16'd320, 16'd3, 16'd2, 16'd2000};
      2: return {16'hFFFF, 16'd1023, 16'd1023, 16'd32767, 16'd32767, 16'hFFFF};
      3: return {16'd0, 16'd1023, 16'd0, 16'd0, 16'd1, 16'd0};
      5: return {16'd4000, 16'd900, 16'd200, 16'd1, 16'd32767, 16'd1};
      6: return {16'd1000, 16'd0, 16'd0, 16'd2, 16'd1, 16'd300};
      default: return '0;
    endcase
  endfunction

  task automatic load_settings(input int row, input bit rnd_set);
    logic [95:0] bits;
    bits = preset_row(row);
    for (int r = fppd_pkg::REG_THRESHOLD_SPEED; r <= fppd_pkg::REG_PRIME_LENGTH; r++)
      write_reg(3'(r), rnd_set ? 16'($urandom)
                               : bits[(fppd_pkg::REG_PRIME_LENGTH - r) * 16 +: 16]);
    if (rnd_set) begin
      for (int r = fppd_pkg::REG_PRIME_LENGTH + 1; r <= REG_SPARE_TOP; r++)
        write_reg(3'(r), 16'($urandom));
    end
  endtask

  task automatic drain();
    while (results_seen != stim_total) @(posedge clk);
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timed out after %0d cycles, %0d of %0d results seen",
             cycle_count, results_seen, stim_total);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int  failures;
    bit  rnd_set;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Registers still at reset: nothing should move.
    queue_item(fppd_pkg::CMD_UPDATE, 8'd255, 16'hFFFF, 32'd0);
    queue_item(fppd_pkg::CMD_POLL, 8'd0, 16'd0, 32'hFFFF_FFFF);
    drain();
    load_settings(0, 1'b0);

    // Same millisecond, truncation of a negative quotient, output saturation at zero.
    queue_item(fppd_pkg::CMD_UPDATE, 8'd0, 16'hFFFF, 32'd0);
    queue_item(fppd_pkg::CMD_UPDATE, 8'd255, 16'd0, 32'd0);
    // Elapsed time past 16 bits, integrator clamp, elapsed of exactly 2^16.
    queue_item(fppd_pkg::CMD_UPDATE, 8'd0, 16'd2000, 32'd70000);
    queue_item(fppd_pkg::CMD_UPDATE, 8'd0, 16'd2000, 32'd135536);
    queue_item(fppd_pkg::CMD_UPDATE, 8'd255, 16'd1999, 32'd201071);
    queue_item(fppd_pkg::CMD_UPDATE, 8'd100, 16'd2000, 32'd201076);
    // Priming: update while priming, early poll, re-arm, poll right at the deadline.
    queue_item(fppd_pkg::CMD_PRIME, 8'd0, 16'd0, 32'd1000);
    queue_item(fppd_pkg::CMD_UPDATE, 8'd255, 16'hFFFF, 32'd1500);
    queue_item(fppd_pkg::CMD_POLL, 8'd0, 16'd0, 32'd1999);
    queue_item(fppd_pkg::CMD_PRIME, 8'd0, 16'd0, 32'd1999);
    queue_item(fppd_pkg::CMD_POLL, 8'd0, 16'd0, 32'd2998);
    queue_item(fppd_pkg::CMD_POLL, 8'd0, 16'd0, 32'd2999);
    queue_item(fppd_pkg::CMD_POLL, 8'd0, 16'd0, 32'd5000);
    queue_item(fppd_pkg::CMD_DISABLE, 8'hFF, 16'hFFFF, 32'd5000);
    // Deadline that wraps past 2^32 ends at the first poll.
    queue_item(fppd_pkg::CMD_PRIME, 8'd0, 16'd0, 32'hFFFF_FF00);
    queue_item(fppd_pkg::CMD_POLL, 8'd0, 16'd0, 32'hFFFF_FF01);
    queue_item(fppd_pkg::CMD_UPDATE, 8'h55, 16'hAAAA, 32'hAAAA_5555);
    queue_item(fppd_pkg::CMD_UPDATE, 8'hAA, 16'h5555, 32'h5555_AAAA);
    queue_item(fppd_pkg::CMD_UPDATE, 8'd128, 16'd2000, 32'hFFFF_FFFF);
    queue_item(fppd_pkg::CMD_DISABLE, 8'd0, 16'd0, 32'd0);

    // Random traffic, one register setting per phase.
    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      drain();
      rnd_set = (ph == 4 || ph == 7);
      load_settings(ph, rnd_set);
      src_steady = (ph == 3 || ph == 6);
      sink_steady = (ph == 4 || ph == 6);
      if (ph == 5) ms_clock = 32'hFFFF_F000;
      for (int n = 0; n < PHASE_ITEMS; n++) queue_random_item();
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    failures = mismatches + duty_expect_q.size();
    $display("Ran %0d items (%0d updates, %0d primes, %0d disables, %0d polls)",
             stim_total, cmd_seen[fppd_pkg::CMD_UPDATE], cmd_seen[fppd_pkg::CMD_PRIME],
             cmd_seen[fppd_pkg::CMD_DISABLE], cmd_seen[fppd_pkg::CMD_POLL]);
    $display("over %0d settings, %0d long back-pressure stretches of %0d cycles, %0d mismatches.",
             NUM_PHASES + 2, holds_done, HOLD_CYCLES, failures);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/fppd_pkg.sv
src/fuel_pressure_pi_pump_drive_unit.sv
tb/fuel_pressure_pi_pump_drive_unit_tb.sv
